// File: src/crs_pkg.sv
// Shared types and constants for the complete ruler search block.
`default_nettype none

package crs_pkg;

	localparam int DEF_WORD_BITS = 32;

	typedef struct packed {
		logic [4:0] ruler_length;
		logic [4:0] mark_count;
	} req_word_t;

	typedef struct packed {
		logic        found;
		logic [31:0] mark_pattern;
	} rsp_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COVER,
		ST_MARK,
		ST_TRY,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic cov_step;
		logic mark_hit;
		logic adv_start;
		logic mark_calc;
		logic take;
		logic skip;
		logic emit;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad;
		logic cov_end;
		logic hit;
		logic blocked;
		logic exhausted;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: src/crs_ctrl.sv
// Sequencing state machine and response valid flag for the ruler search.
`default_nettype none

module crs_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	input  wire crs_pkg::dp_stat_t    stat,
	output crs_pkg::ctrl_cmd_t        cmd
);

	crs_pkg::state_t state_q;
	crs_pkg::state_t state_nxt;
	logic            rsp_valid_q;
	logic            out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= crs_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			crs_pkg::ST_IDLE: begin
				if (req_valid) state_nxt = crs_pkg::ST_COVER;
			end
			crs_pkg::ST_COVER: begin
				priority if (stat.bad) state_nxt = crs_pkg::ST_FINISH;
				else if (stat.cov_end && stat.hit) state_nxt = crs_pkg::ST_FINISH;
				else if (stat.cov_end) state_nxt = crs_pkg::ST_MARK;
				else state_nxt = crs_pkg::ST_COVER;
			end
			crs_pkg::ST_MARK: begin
				state_nxt = crs_pkg::ST_TRY;
			end
			crs_pkg::ST_TRY: begin
				priority if (!stat.blocked) state_nxt = crs_pkg::ST_COVER;
				else if (stat.exhausted) state_nxt = crs_pkg::ST_FINISH;
				else state_nxt = crs_pkg::ST_MARK;
			end
			crs_pkg::ST_FINISH: begin
				if (out_free) state_nxt = crs_pkg::ST_IDLE;
			end
			default: state_nxt = crs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			crs_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			crs_pkg::ST_COVER: begin
				if (!stat.bad) begin
					cmd.cov_step  = !stat.cov_end;
					cmd.mark_hit  = stat.cov_end && stat.hit;
					cmd.adv_start = stat.cov_end && !stat.hit;
				end
			end
			crs_pkg::ST_MARK: begin
				cmd.mark_calc = 1'b1;
			end
			crs_pkg::ST_TRY: begin
				cmd.take = !stat.blocked;
				cmd.skip = stat.blocked && !stat.exhausted;
			end
			crs_pkg::ST_FINISH: begin
				cmd.emit = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == crs_pkg::ST_COVER))
		else $error("accepted request did not start a search");

	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |=> rsp_valid_q)
		else $error("pending response dropped");

	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crs_pkg::ST_FINISH && rsp_valid_q && !rsp_ready)
		|=> (state_q == crs_pkg::ST_FINISH))
		else $error("result overwrote a pending response");
`endif

endmodule

`default_nettype wire

// File: src/crs_dpath.sv
// Candidate, coverage and advance registers of the ruler search.
`default_nettype none

module crs_dpath #(
	parameter int WORD_BITS = crs_pkg::DEF_WORD_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire crs_pkg::req_word_t   req_word,
	input  wire crs_pkg::ctrl_cmd_t   cmd,
	output crs_pkg::dp_stat_t         stat,
	output crs_pkg::rsp_word_t        rsp_word
);

	localparam int SW = $clog2(WORD_BITS);
	localparam logic [WORD_BITS-1:0] ONES = '1;
	localparam logic [WORD_BITS-1:0] ONE  = WORD_BITS'(1);

	// load-time decode
	logic [4:0]           ld_len;
	logic [4:0]           ld_mc;
	logic [4:0]           ld_inner;
	logic                 ld_bad;
	logic [WORD_BITS-1:0] ld_far;
	logic [WORD_BITS-1:0] ld_full;
	logic [WORD_BITS-1:0] ld_r;

	logic                 bad_q;
	logic                 hit_q;
	logic [4:0]           inner_q;
	logic [4:0]           m_q;
	logic [WORD_BITS-1:0] far_q;
	logic [WORD_BITS-1:0] full_q;
	logic [WORD_BITS-1:0] r_q;
	logic [WORD_BITS-1:0] w_q;
	logic [WORD_BITS-1:0] cov_q;
	logic [WORD_BITS-1:0] s_q;
	logic [WORD_BITS-1:0] mark_q;
	logic [WORD_BITS-1:0] lim_q;
	crs_pkg::rsp_word_t   rsp_q;

	logic [WORD_BITS-1:0] w_shl;
	logic [WORD_BITS-1:0] mark_dec;
	logic [WORD_BITS-1:0] pack;
	logic [WORD_BITS-1:0] nxt_r;
	logic [WORD_BITS-1:0] mark_shr;
	logic [5:0]           m_inc;

	assign ld_len   = req_word.ruler_length;
	assign ld_mc    = req_word.mark_count;
	assign ld_inner = ld_mc - 5'd1;
	assign ld_bad   = (ld_mc == 5'd0) || (ld_mc > ld_len) || (int'(ld_len) >= WORD_BITS);
	assign ld_far   = ONE << SW'(WORD_BITS - int'(ld_len));
	assign ld_full  = ~(ONES >> ld_len);
	assign ld_r     = ~(ONES >> ld_inner);

	assign w_shl    = w_q << 1;
	assign m_inc    = 6'(m_q) + 6'd1;
	assign mark_shr = mark_q >> 1;
	// run of m+1 marks, the moved mark first, packed directly below the mark's old bit
	assign mark_dec = mark_q - ONE;
	assign pack     = mark_dec & ~(mark_dec >> m_inc);
	assign nxt_r    = (s_q ^ mark_q) | pack;

	assign stat.bad       = bad_q;
	assign stat.cov_end   = (w_q == '0);
	assign stat.hit       = (cov_q == full_q);
	assign stat.blocked   = (mark_shr == '0) || (mark_shr == lim_q);
	assign stat.exhausted = (m_inc >= 6'(inner_q));

	assign rsp_word = rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bad_q   <= ld_bad;
			inner_q <= ld_inner;
			far_q   <= ld_far;
			full_q  <= ld_full;
			r_q     <= ld_r;
			w_q     <= ld_r | ld_far;
			cov_q   <= ld_r | ld_far;
			hit_q   <= 1'b0;
		end
		if (cmd.cov_step) begin
			w_q <= w_shl;
			if (w_q[WORD_BITS-1]) cov_q <= cov_q | w_shl;
		end
		if (cmd.mark_hit) hit_q <= 1'b1;
		if (cmd.adv_start) begin
			s_q   <= r_q;
			m_q   <= '0;
			lim_q <= far_q;
		end
		if (cmd.mark_calc) mark_q <= s_q & (~s_q + ONE);
		if (cmd.take) begin
			r_q   <= nxt_r;
			w_q   <= nxt_r | far_q;
			cov_q <= nxt_r | far_q;
		end
		if (cmd.skip) begin
			s_q   <= s_q ^ mark_q;
			m_q   <= m_q + 5'd1;
			lim_q <= lim_q << 1;
		end
	end

	// response register, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_q <= '0;
		end else if (cmd.emit) begin
			rsp_q.found        <= hit_q;
			rsp_q.mark_pattern <= hit_q ? 32'(r_q) : 32'd0;
		end
	end

`ifndef SYNTHESIS
	a_mark_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_calc |=> $onehot0(mark_q))
		else $error("isolated mark is not a single bit");

	a_take_keeps_marks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> ($countones(r_q) == $countones($past(r_q))))
		else $error("advance changed the number of marks");

	a_cov_keeps_far: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cov_step && !bad_q) |=> ((cov_q & far_q) == far_q))
		else $error("coverage lost the far mark");
`endif

endmodule

`default_nettype wire

// File: src/complete_ruler_search.sv
// Top level of the complete ruler search: controller plus datapath.
//
// Usage:
//  req channel (req_valid/req_ready/req_word) takes one word holding a ruler
//  length L and a mark count M. rsp channel (rsp_valid/rsp_ready/rsp_word)
//  returns one word per request: found, and the interior marks as a bit word
//  (bit 32-i set = mark at distance i), zero when nothing was found or the
//  request was invalid (M = 0, M > L, or L not held in the word).
//  Candidates are enumerated from the packed start; each is checked by a
//  shift-and-OR coverage unit, one bit position per cycle, and the advance
//  step then examines the marks in turn, each in a mark and a try state,
//  until one can move. The worst case runs to roughly C(30,15) candidates.
//  Invalid requests (checked at load) are answered without a search.
//  One request is searched at a time. The result goes to an output register,
//  so a new request is taken while an earlier response still waits; if the
//  receiver stalls, a finished search holds until that register frees.
//  Reset (arst_n low) aborts any search and drops a pending response.
`default_nettype none

module complete_ruler_search #(
	parameter int WORD_BITS = crs_pkg::DEF_WORD_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire crs_pkg::req_word_t  req_word,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output crs_pkg::rsp_word_t       rsp_word
);

	crs_pkg::ctrl_cmd_t cmd;   // sequencing commands
	crs_pkg::dp_stat_t  stat;  // coverage / advance flags

	crs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// word width follows WORD_BITS; mark word is truncated/extended to 32 bits
	crs_dpath #(
		.WORD_BITS (WORD_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_word (req_word),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_word (rsp_word)
	);

endmodule

`default_nettype wire
